>>> rtl/core/polar_grid_force_resultant_assert.svh
// Assertion macros used by the checker of the polar grid force block.
`ifndef POLAR_GRID_FORCE_RESULTANT_ASSERT_SVH
`define POLAR_GRID_FORCE_RESULTANT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PGFR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PGFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pgfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfr_pkg
// Shared types, constants and tables of the polar grid force resultant block.
// ----------------------------------------------------------------------------
package pgfr_pkg;

  // Default grid dimensions.
  localparam int MAX_AZ_BINS_DEF = 64;
  localparam int MAX_EL_BINS_DEF = 32;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_AZ  = 3'd0;
  localparam logic [2:0] REG_AZ_STEP = 3'd1;
  localparam logic [2:0] REG_MIN_EL  = 3'd2;
  localparam logic [2:0] REG_EL_STEP = 3'd3;
  localparam logic [2:0] REG_GOAL_X  = 3'd4;
  localparam logic [2:0] REG_GOAL_Y  = 3'd5;
  localparam logic [2:0] REG_GOAL_Z  = 3'd6;

  // Register reset values.
  localparam logic signed [15:0] RST_MIN_AZ  = -16'sd25736;
  localparam logic [14:0]        RST_AZ_STEP = 15'd804;
  localparam logic signed [15:0] RST_MIN_EL  = -16'sd12868;
  localparam logic [14:0]        RST_EL_STEP = 15'd804;
  localparam logic signed [15:0] RST_GOAL_X  = 16'sd16384;
  localparam logic signed [15:0] RST_GOAL_Y  = 16'sd0;
  localparam logic signed [15:0] RST_GOAL_Z  = 16'sd0;

  // Angle constants in units of 2^-16 rad.
  localparam logic [18:0]        TWO_PI_U  = 19'd411775;
  localparam logic signed [20:0] TWO_PI_S  = 21'sd411775;
  localparam logic signed [20:0] PI_S      = 21'sd205887;
  localparam logic signed [20:0] HALF_PI_S = 21'sd102944;

  // CORDIC gain pre-compensation in Q30.
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // Running sum of one axis, in units of 2^-14 of the bin magnitude.
  typedef logic signed [43:0] pgfr_sum_t;

  // Cosine and sine of one angle, Q30.
  typedef struct packed {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } pgfr_sc_t;

  // Arctangent of 2^-i in units of 2^-16 rad.
  function automatic logic [15:0] atan_lut(input logic [3:0] i);
    logic [15:0] r;
    unique case (i)
      4'd0:  r = 16'd51472;
      4'd1:  r = 16'd30385;
      4'd2:  r = 16'd16055;
      4'd3:  r = 16'd8150;
      4'd4:  r = 16'd4091;
      4'd5:  r = 16'd2047;
      4'd6:  r = 16'd1024;
      4'd7:  r = 16'd512;
      4'd8:  r = 16'd256;
      4'd9:  r = 16'd128;
      4'd10: r = 16'd64;
      4'd11: r = 16'd32;
      4'd12: r = 16'd16;
      4'd13: r = 16'd8;
      4'd14: r = 16'd4;
      4'd15: r = 16'd2;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/core/pgfr_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfr_cordic
// Iterative sine and cosine of a bin-centre angle: range reduction by
// shifted subtraction, quadrant folding and sixteen CORDIC rotations.
// ----------------------------------------------------------------------------
module pgfr_cordic import pgfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [15:0] min_i,
  input  logic [14:0]        step_i,
  input  logic [5:0]         index_i,
  output logic               done_o,
  output pgfr_sc_t           sc_o
);

  localparam logic [2:0] C_IDLE = 3'd0;
  localparam logic [2:0] C_RED  = 3'd1;
  localparam logic [2:0] C_FOLD = 3'd2;
  localparam logic [2:0] C_ITER = 3'd3;
  localparam logic [2:0] C_FIN  = 3'd4;

  // Clamp a rotated value to plus or minus one in Q30.
  function automatic logic signed [31:0] clamp_q30(input logic signed [32:0] v);
    if (v > 33'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -33'sd1073741824) begin
      return -32'sd1073741824;
    end else begin
      return 32'(v);
    end
  endfunction

  logic [2:0]         st_q, st_d;
  logic [3:0]         cnt_q, cnt_d;
  logic               done_q, done_d;
  logic [24:0]        amag_q, amag_d;
  logic               aneg_q, aneg_d;
  logic signed [19:0] z_q, z_d;
  logic signed [32:0] x_q, x_d, y_q, y_d;
  logic               neg_q, neg_d;
  pgfr_sc_t           sc_q, sc_d;

  logic [21:0]        odd_prod;
  logic signed [25:0] ang;
  logic [24:0]        twopi_sh;
  logic signed [20:0] r0, r1, r2;
  logic               fneg;
  logic signed [32:0] xs, ys, xn, yn;
  logic signed [19:0] ad;

  // Bin-centre angle: 4 * (2 * min + (2 * index + 1) * step).
  assign odd_prod = {index_i, 1'b1} * step_i;
  assign ang      = ((26'(min_i) <<< 1) + $signed({4'd0, odd_prod})) <<< 2;

  // Multiple of two pi tried in this reduction step.
  assign twopi_sh = {6'd0, TWO_PI_U} << (3'd5 - cnt_q[2:0]);

  // Fold the reduced angle into the right half plane.
  always_comb begin
    r0 = aneg_q ? -$signed({1'b0, amag_q[19:0]}) : $signed({1'b0, amag_q[19:0]});
    if (r0 > PI_S) begin
      r1 = r0 - TWO_PI_S;
    end else if (r0 < -PI_S) begin
      r1 = r0 + TWO_PI_S;
    end else begin
      r1 = r0;
    end
    fneg = 1'b0;
    if (r1 > HALF_PI_S) begin
      r2   = r1 - PI_S;
      fneg = 1'b1;
    end else if (r1 < -HALF_PI_S) begin
      r2   = r1 + PI_S;
      fneg = 1'b1;
    end else begin
      r2 = r1;
    end
  end

  // Shifts that truncate toward zero.
  assign xs = x_q[32] ? -((-x_q) >>> cnt_q) : (x_q >>> cnt_q);
  assign ys = y_q[32] ? -((-y_q) >>> cnt_q) : (y_q >>> cnt_q);
  assign ad = $signed({4'd0, atan_lut(cnt_q)});
  assign xn = neg_q ? -x_q : x_q;
  assign yn = neg_q ? -y_q : y_q;

  // Sequencer of the shared rotation unit.
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    amag_d = amag_q;
    aneg_d = aneg_q;
    z_d    = z_q;
    x_d    = x_q;
    y_d    = y_q;
    neg_d  = neg_q;
    sc_d   = sc_q;
    unique case (st_q)
      C_IDLE: begin
        if (start_i) begin
          amag_d = ang[25] ? 25'(-ang) : 25'(ang);
          aneg_d = ang[25];
          cnt_d  = 4'd0;
          st_d   = C_RED;
        end
      end
      C_RED: begin
        if (amag_q >= twopi_sh) begin
          amag_d = amag_q - twopi_sh;
        end
        if (cnt_q == 4'd5) begin
          st_d = C_FOLD;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      C_FOLD: begin
        z_d   = 20'(r2);
        neg_d = fneg;
        x_d   = CORDIC_GAIN;
        y_d   = '0;
        cnt_d = 4'd0;
        st_d  = C_ITER;
      end
      C_ITER: begin
        if (!z_q[19]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - ad;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + ad;
        end
        if (cnt_q == 4'd15) begin
          st_d = C_FIN;
        end else begin
          cnt_d = cnt_q + 4'd1;
        end
      end
      C_FIN: begin
        sc_d.cos_v = clamp_q30(xn);
        sc_d.sin_v = clamp_q30(yn);
        done_d     = 1'b1;
        st_d       = C_IDLE;
      end
      default: begin
        st_d = C_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= C_IDLE;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    amag_q <= amag_d;
    aneg_q <= aneg_d;
    z_q    <= z_d;
    x_q    <= x_d;
    y_q    <= y_d;
    neg_q  <= neg_d;
    sc_q   <= sc_d;
  end

  assign done_o = done_q;
  assign sc_o   = sc_q;

endmodule

>>> rtl/core/pgfr_norm.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfr_norm
// Iterative normalizer: power-of-two scaling, sum of squares, bitwise
// square root and restoring division of each component, giving Q1.14.
// ----------------------------------------------------------------------------
module pgfr_norm import pgfr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  pgfr_sum_t          v_i [3],
  output logic               done_o,
  output logic signed [15:0] dir_o [3]
);

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_DOWN = 3'd1;
  localparam logic [2:0] N_UP   = 3'd2;
  localparam logic [2:0] N_SQ   = 3'd3;
  localparam logic [2:0] N_SQRT = 3'd4;
  localparam logic [2:0] N_DLD  = 3'd5;
  localparam logic [2:0] N_DST  = 3'd6;
  localparam logic [2:0] N_DWR  = 3'd7;

  localparam logic [43:0] ONE_Q30  = 44'd1 << 30;
  localparam logic [43:0] HALF_Q30 = 44'd1 << 29;
  localparam logic [15:0] ONE_Q14  = 16'd16384;

  logic [2:0]         st_q, st_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [1:0]         cmp_q, cmp_d;
  logic               done_q, done_d;
  pgfr_sum_t          w_q [3];
  pgfr_sum_t          w_d [3];
  logic [43:0]        m_q, m_d;
  logic [63:0]        sq_q, sq_d;
  logic [62:0]        res_q, res_d;
  logic [31:0]        rem_q, rem_d;
  logic [15:0]        dvd_q, dvd_d, quo_q, quo_d;
  logic signed [15:0] dir_q [3];
  logic signed [15:0] dir_d [3];

  logic [43:0]        av [3];
  logic [43:0]        mx;
  logic signed [30:0] wl;
  logic signed [61:0] wsq;
  logic [62:0]        bitv, trial;
  logic [31:0]        nrm;
  logic [30:0]        aw;
  logic [45:0]        dend;
  logic [32:0]        tdiv;
  logic               ge;
  logic [15:0]        qc;

  // Largest absolute component of the incoming vector.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      av[i] = v_i[i][43] ? 44'(-v_i[i]) : 44'(v_i[i]);
    end
    mx = av[0];
    if (av[1] > mx) mx = av[1];
    if (av[2] > mx) mx = av[2];
  end

  // Operands of the square, root and division steps.
  assign wl    = 31'(w_q[cmp_q == 2'd3 ? 2'd0 : cnt_q[1:0]]);
  assign wsq   = wl * wl;
  assign bitv  = 63'd1 << (6'd62 - {cnt_q, 1'b0});
  assign trial = res_q + bitv;
  assign nrm   = res_q[31:0];
  assign aw    = w_q[cmp_q][43] ? 31'(-w_q[cmp_q]) : 31'(w_q[cmp_q]);
  assign dend  = (46'(aw) << 14) + 46'(nrm >> 1);
  assign tdiv  = {rem_q, dvd_q[15]};
  assign ge    = tdiv >= {1'b0, nrm};
  assign qc    = (quo_q > ONE_Q14) ? ONE_Q14 : quo_q;

  // Normalizer sequencer.
  always_comb begin
    st_d   = st_q;
    cnt_d  = cnt_q;
    cmp_d  = cmp_q;
    done_d = 1'b0;
    w_d    = w_q;
    m_d    = m_q;
    sq_d   = sq_q;
    res_d  = res_q;
    rem_d  = rem_q;
    dvd_d  = dvd_q;
    quo_d  = quo_q;
    dir_d  = dir_q;
    unique case (st_q)
      N_IDLE: begin
        if (start_i) begin
          if (mx == '0) begin
            for (int i = 0; i < 3; i++) dir_d[i] = '0;
            done_d = 1'b1;
          end else begin
            w_d  = v_i;
            m_d  = mx;
            st_d = N_DOWN;
          end
        end
      end
      N_DOWN: begin
        if (m_q >= ONE_Q30) begin
          for (int i = 0; i < 3; i++) begin
            w_d[i] = w_q[i][43] ? -((-w_q[i]) >>> 1) : (w_q[i] >>> 1);
          end
          m_d = m_q >> 1;
        end else begin
          st_d = N_UP;
        end
      end
      N_UP: begin
        if (m_q < HALF_Q30) begin
          for (int i = 0; i < 3; i++) w_d[i] = w_q[i] <<< 1;
          m_d = m_q << 1;
        end else begin
          sq_d  = '0;
          cnt_d = '0;
          cmp_d = 2'd0;
          st_d  = N_SQ;
        end
      end
      N_SQ: begin
        sq_d = sq_q + 64'($unsigned(wsq));
        if (cnt_q == 5'd2) begin
          cnt_d = '0;
          res_d = '0;
          st_d  = N_SQRT;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_SQRT: begin
        if (sq_q >= 64'(trial)) begin
          sq_d  = sq_q - 64'(trial);
          res_d = (res_q >> 1) + bitv;
        end else begin
          res_d = res_q >> 1;
        end
        if (cnt_q == 5'd31) begin
          cmp_d = 2'd0;
          st_d  = N_DLD;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_DLD: begin
        rem_d = 32'(dend >> 16);
        dvd_d = dend[15:0];
        quo_d = '0;
        cnt_d = '0;
        st_d  = N_DST;
      end
      N_DST: begin
        if (ge) begin
          rem_d = 32'(tdiv - {1'b0, nrm});
        end else begin
          rem_d = 32'(tdiv);
        end
        quo_d = {quo_q[14:0], ge};
        dvd_d = dvd_q << 1;
        if (cnt_q == 5'd15) begin
          st_d = N_DWR;
        end else begin
          cnt_d = cnt_q + 5'd1;
        end
      end
      N_DWR: begin
        dir_d[cmp_q] = w_q[cmp_q][43] ? -$signed(qc) : $signed(qc);
        if (cmp_q == 2'd2) begin
          done_d = 1'b1;
          st_d   = N_IDLE;
        end else begin
          cmp_d = cmp_q + 2'd1;
          st_d  = N_DLD;
        end
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= N_IDLE;
      cnt_q  <= '0;
      cmp_q  <= '0;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      cnt_q  <= cnt_d;
      cmp_q  <= cmp_d;
      done_q <= done_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    m_q   <= m_d;
    sq_q  <= sq_d;
    res_q <= res_d;
    rem_q <= rem_d;
    dvd_q <= dvd_d;
    quo_q <= quo_d;
    dir_q <= dir_d;
  end

  assign done_o = done_q;
  assign dir_o  = dir_q;

endmodule

>>> rtl/core/polar_grid_force_resultant.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polar_grid_force_resultant
// Accumulates polar grid force bins into a Cartesian resultant and emits
// its unit direction, or the normalized goal when the resultant vanishes.
// ----------------------------------------------------------------------------
// One bin is taken at a time and s_axis_tready stays low until it is done.
// A bin with positive magnitude inside the grid makes two passes through
// the shared CORDIC unit (six reduction steps, a fold, sixteen rotations),
// then products on the shared 32 by 32 multiplier, rounding and
// accumulation over the three axes, and one closing step. A skipped bin
// goes straight to the closing step. A bin marked last then adds
// normalization (scaling shifts, three squares, a 32-step square root and
// three 16-step divisions) before the result word is offered; the next bin
// is accepted while that word still waits on m_axis_tready.
module polar_grid_force_resultant import pgfr_pkg::*; #(
  parameter int MAX_AZ_BINS = MAX_AZ_BINS_DEF,
  parameter int MAX_EL_BINS = MAX_EL_BINS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // magnitude [15:0], az_index [21:16], el_index [26:22], zero fill above
  input  logic [31:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // dir_x [15:0], dir_y [31:16], dir_z [47:32]
  output logic [47:0] m_axis_tdata,
  // used_goal [0]
  output logic        m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_AZ   = 4'd1;
  localparam logic [3:0] S_EL   = 4'd2;
  localparam logic [3:0] S_MULA = 4'd3;
  localparam logic [3:0] S_RND  = 4'd4;
  localparam logic [3:0] S_MULB = 4'd5;
  localparam logic [3:0] S_ACC  = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_NORM = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  localparam logic signed [44:0] SUM_LIM = 45'sd8796093022207;

  // Round a Q60 product to Q14, half away from zero.
  function automatic logic signed [15:0] rnd46(input logic signed [63:0] v);
    logic [63:0] a;
    a = v[63] ? 64'(-v) : 64'(v);
    a = (a + 64'd35184372088832) >> 46;
    return v[63] ? -$signed(16'(a)) : $signed(16'(a));
  endfunction

  // Round a Q30 value to Q14, half away from zero.
  function automatic logic signed [15:0] rnd16(input logic signed [31:0] v);
    logic [31:0] a;
    a = v[31] ? 32'(-v) : 32'(v);
    a = (a + 32'd32768) >> 16;
    return v[31] ? -$signed(16'(a)) : $signed(16'(a));
  endfunction

  // True when a sum is within four units of zero.
  function automatic logic is_tiny(input pgfr_sum_t v);
    return (v > -44'sd5) && (v < 44'sd5);
  endfunction

  // Square of a tiny sum, taken from its low bits.
  function automatic logic [5:0] tiny_sq(input pgfr_sum_t v);
    logic signed [3:0] t;
    logic signed [7:0] p;
    t = v[3:0];
    p = t * t;
    return p[5:0];
  endfunction

  // Configuration registers.
  logic signed [15:0] min_az_q, min_el_q, goal_x_q, goal_y_q, goal_z_q;
  logic [14:0]        az_step_q, el_step_q;

  // Sequencer and datapath.
  logic [3:0]         st_q, st_d;
  logic [1:0]         axis_q, axis_d;
  logic signed [15:0] mag_q, mag_d;
  logic [4:0]         el_q, el_d;
  logic               last_q, last_d;
  pgfr_sc_t           az_sc_q, az_sc_d, el_sc_q, el_sc_d;
  logic signed [63:0] p_q, p_d;
  logic signed [15:0] comp_q, comp_d;
  pgfr_sum_t          sum_q [3];
  pgfr_sum_t          sum_d [3];
  logic               used_q, used_d;
  logic               out_valid_q, out_valid_d;
  logic [47:0]        out_data_q, out_data_d;
  logic               out_user_q, out_user_d;

  logic signed [15:0] in_mag;
  logic [5:0]         in_az;
  logic [4:0]         in_el;
  logic               accept, bin_ok;
  logic               cor_start, cor_done;
  logic signed [15:0] cor_min;
  logic [14:0]        cor_step;
  logic [5:0]         cor_index;
  pgfr_sc_t           cor_sc;
  logic signed [31:0] op_a, op_b;
  logic signed [63:0] prod;
  logic signed [44:0] acc_sum;
  logic               vanish;
  logic [7:0]         sq_small;
  logic               norm_start, norm_done;
  pgfr_sum_t          norm_v [3];
  logic signed [15:0] norm_dir [3];

  assign in_mag = $signed(s_axis_tdata[15:0]);
  assign in_az  = s_axis_tdata[21:16];
  assign in_el  = s_axis_tdata[26:22];
  assign accept = s_axis_tvalid && s_axis_tready;
  assign bin_ok = (in_mag > 16'sd0) && ({26'd0, in_az} < 32'(MAX_AZ_BINS)) &&
                  ({27'd0, in_el} < 32'(MAX_EL_BINS));

  assign s_axis_tready = (st_q == S_IDLE);

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_az_q  <= RST_MIN_AZ;
      az_step_q <= RST_AZ_STEP;
      min_el_q  <= RST_MIN_EL;
      el_step_q <= RST_EL_STEP;
      goal_x_q  <= RST_GOAL_X;
      goal_y_q  <= RST_GOAL_Y;
      goal_z_q  <= RST_GOAL_Z;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MIN_AZ:  min_az_q  <= $signed(cfg_data_i);
        REG_AZ_STEP: az_step_q <= cfg_data_i[14:0];
        REG_MIN_EL:  min_el_q  <= $signed(cfg_data_i);
        REG_EL_STEP: el_step_q <= cfg_data_i[14:0];
        REG_GOAL_X:  goal_x_q  <= $signed(cfg_data_i);
        REG_GOAL_Y:  goal_y_q  <= $signed(cfg_data_i);
        REG_GOAL_Z:  goal_z_q  <= $signed(cfg_data_i);
        default: ;
      endcase
    end
  end

  // The azimuth pass starts on acceptance, the elevation pass after it.
  assign cor_min   = (st_q == S_IDLE) ? min_az_q : min_el_q;
  assign cor_step  = (st_q == S_IDLE) ? az_step_q : el_step_q;
  assign cor_index = (st_q == S_IDLE) ? in_az : {1'b0, el_q};

  pgfr_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cor_start),
    .min_i   (cor_min),
    .step_i  (cor_step),
    .index_i (cor_index),
    .done_o  (cor_done),
    .sc_o    (cor_sc)
  );

  // Shared multiplier: trig product first, then magnitude times component.
  always_comb begin
    if (st_q == S_MULA) begin
      op_a = (axis_q == 2'd0) ? az_sc_q.cos_v : az_sc_q.sin_v;
      op_b = el_sc_q.cos_v;
    end else begin
      op_a = 32'(mag_q);
      op_b = 32'(comp_q);
    end
  end
  assign prod = op_a * op_b;

  // Saturating accumulate into the selected axis.
  always_comb begin
    acc_sum = 45'(sum_q[axis_q]) + 45'(p_q);
    if (acc_sum > SUM_LIM) begin
      acc_sum = SUM_LIM;
    end else if (acc_sum < -SUM_LIM) begin
      acc_sum = -SUM_LIM;
    end
  end

  // Vanishing resultant test and the vector handed to the normalizer.
  assign sq_small = 8'(tiny_sq(sum_q[0])) + 8'(tiny_sq(sum_q[1])) +
                    8'(tiny_sq(sum_q[2]));
  assign vanish   = is_tiny(sum_q[0]) && is_tiny(sum_q[1]) && is_tiny(sum_q[2]) &&
                    (sq_small <= 8'd17);
  assign norm_v[0] = vanish ? 44'(goal_x_q) : sum_q[0];
  assign norm_v[1] = vanish ? 44'(goal_y_q) : sum_q[1];
  assign norm_v[2] = vanish ? 44'(goal_z_q) : sum_q[2];

  pgfr_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .v_i     (norm_v),
    .done_o  (norm_done),
    .dir_o   (norm_dir)
  );

  // Main sequencer.
  always_comb begin
    st_d        = st_q;
    axis_d      = axis_q;
    mag_d       = mag_q;
    el_d        = el_q;
    last_d      = last_q;
    az_sc_d     = az_sc_q;
    el_sc_d     = el_sc_q;
    p_d         = p_q;
    comp_d      = comp_q;
    sum_d       = sum_q;
    used_d      = used_q;
    cor_start   = 1'b0;
    norm_start  = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          mag_d  = in_mag;
          el_d   = in_el;
          last_d = s_axis_tlast;
          if (bin_ok) begin
            cor_start = 1'b1;
            st_d      = S_AZ;
          end else begin
            st_d = S_FIN;
          end
        end
      end
      S_AZ: begin
        if (cor_done) begin
          az_sc_d   = cor_sc;
          cor_start = 1'b1;
          st_d      = S_EL;
        end
      end
      S_EL: begin
        if (cor_done) begin
          el_sc_d = cor_sc;
          axis_d  = 2'd0;
          st_d    = S_MULA;
        end
      end
      S_MULA: begin
        p_d  = prod;
        st_d = S_RND;
      end
      S_RND: begin
        comp_d = (axis_q == 2'd2) ? rnd16(el_sc_q.sin_v) : rnd46(p_q);
        st_d   = S_MULB;
      end
      S_MULB: begin
        p_d  = prod;
        st_d = S_ACC;
      end
      S_ACC: begin
        sum_d[axis_q] = 44'(acc_sum);
        if (axis_q == 2'd2) begin
          st_d = S_FIN;
        end else begin
          axis_d = axis_q + 2'd1;
          st_d   = (axis_q == 2'd1) ? S_RND : S_MULA;
        end
      end
      S_FIN: begin
        if (last_q) begin
          norm_start = 1'b1;
          used_d     = vanish;
          for (int i = 0; i < 3; i++) sum_d[i] = '0;
          st_d = S_NORM;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_NORM: begin
        if (norm_done) begin
          st_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_data_d  = {norm_dir[2], norm_dir[1], norm_dir[0]};
          out_user_d  = used_q;
          st_d        = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 3; i++) sum_q[i] <= '0;
    end else begin
      st_q        <= st_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
      sum_q       <= sum_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    el_q       <= el_d;
    last_q     <= last_d;
    az_sc_q    <= az_sc_d;
    el_sc_q    <= el_sc_d;
    p_q        <= p_d;
    comp_q     <= comp_d;
    used_q     <= used_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

>>> rtl/core/pgfr_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgfr_checker
// Port-level checks of the polar grid force resultant block, bound to the
// top level.
// ----------------------------------------------------------------------------
`include "polar_grid_force_resultant_assert.svh"

module pgfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic        m_axis_tuser
);

  // A stalled result word stays on the port unchanged.
  `PGFR_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result word lost or changed while stalled")

  // The block is busy in the cycle after it takes a word.
  `PGFR_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken again straight after a word")

  // No result can appear in the cycle after a word is taken.
  `PGFR_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result offered too early after a word")

  // Direction components are clamped to plus or minus one, so the most
  // negative code never appears in an offered word.
  `PGFR_ASSERT_SAME(a_dir_range, m_axis_tvalid, m_axis_tdata[15:0] != 16'h8000 && m_axis_tdata[31:16] != 16'h8000 && m_axis_tdata[47:32] != 16'h8000, "direction component out of range")

endmodule

bind polar_grid_force_resultant pgfr_checker u_pgfr_checker (.*);
